>>> rtl/core/downmix_cubic_resampler_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the downmix cubic resampler checker
// Each macro expands to one labeled concurrent assertion on aclk.
// ----------------------------------------------------------------------------
`ifndef DOWNMIX_CUBIC_RESAMPLER_ASSERT_SVH
`define DOWNMIX_CUBIC_RESAMPLER_ASSERT_SVH

// Checked at every edge outside reset.
`define DCR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("dcr: port property violated");

// Checked at every edge, reset included.
`define DCR_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("dcr: port property violated");

`endif

>>> rtl/core/dcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcr_pkg: shared types and constants
// Sample format, phase format, queue entry layout and the saturate helper.
// ----------------------------------------------------------------------------
package dcr_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int MAX_CHANNELS    = 8;
    localparam int PHASE_FRAC_BITS = 16;
    localparam int MAX_OUTPUTS     = 8;
    localparam int TQ_BITS         = 12;
    localparam int QUEUE_DEPTH     = 2;

    localparam int CHAN_W     = 4;
    localparam int STEP_W     = 20;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;

    // phase accumulator: whole units up to MAX_OUTPUTS plus fraction
    localparam int CNT_W  = $clog2(MAX_OUTPUTS + 1);
    localparam int ACC_W  = PHASE_FRAC_BITS + CNT_W;
    // interpolation position, down to -(MAX_OUTPUTS-1) units
    localparam int TQ_W   = TQ_BITS + $clog2(MAX_OUTPUTS) + 1;
    localparam int COEF_W = SAMPLE_BITS + 5;
    // Horner partial sums grow by the integer bits of t at each step
    localparam int V_W    = SAMPLE_BITS + 29;
    localparam int PROD_W = V_W + TQ_W;

    localparam int S_TDATA_W = MAX_CHANNELS * SAMPLE_BITS;
    localparam int M_TDATA_W = 2 * SAMPLE_BITS;

    localparam int MAX_SAMPLE = 2 ** (SAMPLE_BITS - 1) - 1;
    localparam int MIN_SAMPLE = -(2 ** (SAMPLE_BITS - 1));

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_COUNT = 1'b0,
        REG_PHASE_STEP    = 1'b1
    } cfg_reg_t;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        sample_t right;
        sample_t left;
    } pair_t;

    // One unit of work handed from the front end to the back end
    typedef struct packed {
        pair_t [3:0]        hist;    // index 0 oldest, 3 newest
        logic [ACC_W-1:0]   acc;     // saturated accumulator after the step
        logic [CNT_W-1:0]   count;   // results this frame causes
        logic               bypass;  // pass the newest pair through
        logic               mark;    // buffer end pending for first result
    } job_t;

    function automatic sample_t sat_sample(input logic signed [V_W-1:0] v);
        logic signed [V_W-1:0] hi;
        logic signed [V_W-1:0] lo;
        sample_t               r;
        hi = V_W'(MAX_SAMPLE);
        lo = V_W'(MIN_SAMPLE);
        if (v > hi) begin
            r = sample_t'(hi);
        end else if (v < lo) begin
            r = sample_t'(lo);
        end else begin
            r = sample_t'(v);
        end
        return r;
    endfunction

endpackage

>>> rtl/core/dcr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcr_front: frame intake, downmix and phase bookkeeping
// Holds the registers, mixes each frame to stereo, keeps the history and the
// phase accumulator, and posts one job per frame that yields results.
// ----------------------------------------------------------------------------
module dcr_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dcr_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [dcr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [dcr_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                             s_tlast,
    output logic                             job_valid,
    input  logic                             job_ready,
    output dcr_pkg::job_t                    job
);

    localparam int F     = dcr_pkg::PHASE_FRAC_BITS;
    localparam int SB    = dcr_pkg::SAMPLE_BITS;
    localparam int NCH   = dcr_pkg::MAX_CHANNELS;
    localparam int CW    = dcr_pkg::CHAN_W;
    localparam int SW    = dcr_pkg::STEP_W;
    localparam int AW    = dcr_pkg::ACC_W;
    localparam int NW    = dcr_pkg::CNT_W;
    localparam int MIX_W = SB + 4;
    localparam int SUM_W = SW + 1;
    localparam int unsigned UNITY = 1 << F;
    localparam int unsigned TOL   = UNITY / 10000;
    localparam int unsigned LIMIT = (dcr_pkg::MAX_OUTPUTS << F) | (UNITY - 1);

    logic [CW-1:0]           chan_count_reg;
    logic [SW-1:0]           step_reg;
    logic [F-1:0]            phase_reg;
    logic                    held_mark_reg;
    dcr_pkg::pair_t [3:0]    hist_reg;

    dcr_pkg::sample_t        smp [NCH];
    logic [CW-1:0]           n_eff;
    logic signed [MIX_W-1:0] extra;
    logic signed [MIX_W-1:0] sum_l;
    logic signed [MIX_W-1:0] sum_r;
    dcr_pkg::pair_t          mixed;
    dcr_pkg::pair_t [3:0]    hist_next;
    logic [SW-1:0]           step_diff;
    logic                    bypass;
    logic [SUM_W-1:0]        acc_sum;
    logic [AW-1:0]           acc_sat;
    logic [NW-1:0]           out_count;
    logic                    mark_now;
    logic                    emits;
    logic                    accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = job_ready;
    assign accept    = s_tvalid & s_tready;

    // unpack channels, clamp the channel count
    always_comb begin
        for (int i = 0; i < NCH; i++) begin
            smp[i] = s_tdata[i*SB +: SB];
        end
        if (chan_count_reg == '0) begin
            n_eff = CW'(1);
        end else if (chan_count_reg > CW'(NCH)) begin
            n_eff = CW'(NCH);
        end else begin
            n_eff = chan_count_reg;
        end
    end

    // downmix in half-LSB units, floor halve, clamp
    always_comb begin
        extra = '0;
        for (int i = 2; i < NCH; i++) begin
            if (CW'(i) < n_eff) begin
                extra = extra + MIX_W'(smp[i]);
            end
        end
        sum_l = (MIX_W'(smp[0]) <<< 1) + extra;
        if (n_eff > CW'(1)) begin
            sum_r = (MIX_W'(smp[1]) <<< 1) + extra;
        end else begin
            sum_r = (MIX_W'(smp[0]) <<< 1) + extra;
        end
        mixed.left  = dcr_pkg::sat_sample(dcr_pkg::V_W'(sum_l >>> 1));
        mixed.right = dcr_pkg::sat_sample(dcr_pkg::V_W'(sum_r >>> 1));
    end

    // history shift, newest at the top
    always_comb begin
        hist_next[0] = hist_reg[1];
        hist_next[1] = hist_reg[2];
        hist_next[2] = hist_reg[3];
        hist_next[3] = mixed;
    end

    // bypass test and phase step
    always_comb begin
        if (step_reg > SW'(UNITY)) begin
            step_diff = step_reg - SW'(UNITY);
        end else begin
            step_diff = SW'(UNITY) - step_reg;
        end
        bypass  = (step_diff <= SW'(TOL));
        acc_sum = SUM_W'(phase_reg) + SUM_W'(step_reg);
        if (acc_sum > SUM_W'(LIMIT)) begin
            acc_sat = AW'(LIMIT);
        end else begin
            acc_sat = acc_sum[AW-1:0];
        end
        out_count = bypass ? NW'(1) : acc_sat[AW-1:F];
        mark_now  = held_mark_reg | s_tlast;
        emits     = bypass | (out_count != '0);
    end

    assign job_valid  = s_tvalid & emits;
    assign job.hist   = hist_next;
    assign job.acc    = acc_sat;
    assign job.count  = out_count;
    assign job.bypass = bypass;
    assign job.mark   = mark_now;

    // registers and per-frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_count_reg <= CW'(2);
            step_reg       <= SW'(UNITY);
            phase_reg      <= '0;
            held_mark_reg  <= 1'b0;
            hist_reg       <= '0;
        end else begin
            if (cfg_valid) begin
                case (dcr_pkg::cfg_reg_t'(cfg_addr))
                    dcr_pkg::REG_CHANNEL_COUNT: begin
                        chan_count_reg <= cfg_wdata[CW-1:0];
                    end
                    dcr_pkg::REG_PHASE_STEP: begin
                        step_reg <= cfg_wdata[SW-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                hist_reg      <= hist_next;
                held_mark_reg <= emits ? 1'b0 : mark_now;
                if (!bypass) begin
                    phase_reg <= acc_sat[F-1:0];
                end
            end
        end
    end

endmodule

>>> rtl/core/dcr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcr_queue: job queue between front and back end
// Shift queue; the head is always slot 0, a push lands behind the last entry.
// ----------------------------------------------------------------------------
module dcr_queue #(
    parameter int DEPTH = dcr_pkg::QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  dcr_pkg::job_t in_job,
    output logic          out_valid,
    input  logic          out_ready,
    output dcr_pkg::job_t out_job
);

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    dcr_pkg::job_t     slot_reg  [DEPTH];
    dcr_pkg::job_t     slot_next [DEPTH];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W-1:0] wr_pos;
    logic              push;
    logic              pop;

    assign in_ready  = (fill_reg != FILL_W'(DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_job   = slot_reg[0];
    assign push      = in_valid & in_ready;
    assign pop       = out_valid & out_ready;

    // advance on pop, write behind the remaining entries on push
    always_comb begin
        slot_next = slot_reg;
        if (pop) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                slot_next[i] = slot_reg[i+1];
            end
        end
        wr_pos = fill_reg - FILL_W'(pop);
        if (push) begin
            slot_next[wr_pos[IDX_W-1:0]] = in_job;
        end
        fill_next = fill_reg + FILL_W'(push) - FILL_W'(pop);
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

endmodule

>>> rtl/core/dcr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcr_back: Catmull-Rom interpolation engine
// Takes one job, forms the cubic coefficients for both sides, then per result
// walks the Horner steps on one multiplier per side and posts the pair.
// ----------------------------------------------------------------------------
module dcr_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           job_valid,
    output logic                           job_ready,
    input  dcr_pkg::job_t                  job,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dcr_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tlast,
    output logic                           m_tuser
);

    localparam int F   = dcr_pkg::PHASE_FRAC_BITS;
    localparam int TQB = dcr_pkg::TQ_BITS;
    localparam int CW  = dcr_pkg::COEF_W;
    localparam int VW  = dcr_pkg::V_W;
    localparam int PW  = dcr_pkg::PROD_W;
    localparam int TW  = dcr_pkg::TQ_W;
    localparam int AW  = dcr_pkg::ACC_W;
    localparam int NW  = dcr_pkg::CNT_W;
    localparam int unsigned UNITY = 1 << F;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PHASE,
        ST_MUL,
        ST_FIN
    } state_t;

    // Horner order: c3, c2, c1, c0
    typedef logic [3:0][CW-1:0] horner_t;

    function automatic horner_t horner_coefs(input dcr_pkg::sample_t a,
                                             input dcr_pkg::sample_t b,
                                             input dcr_pkg::sample_t c,
                                             input dcr_pkg::sample_t d);
        logic signed [CW-1:0] ea;
        logic signed [CW-1:0] eb;
        logic signed [CW-1:0] ec;
        logic signed [CW-1:0] ed;
        horner_t              h;
        ea = CW'(a);
        eb = CW'(b);
        ec = CW'(c);
        ed = CW'(d);
        h[0] = CW'(ed - ea + (eb - ec) * 3);
        h[1] = CW'((ea <<< 1) - eb * 5 + (ec <<< 2) - ed);
        h[2] = CW'(ec - ea);
        h[3] = CW'(eb <<< 1);
        return h;
    endfunction

    state_t                state_reg, state_next;
    logic [1:0]            hstep_reg, hstep_next;
    logic [NW-1:0]         rem_reg, rem_next;
    logic [AW-1:0]         acc_reg, acc_next;
    logic signed [TW-1:0]  tq_reg, tq_next;
    horner_t               hl_reg, hl_next;
    horner_t               hr_reg, hr_next;
    logic signed [PW-1:0]  prod_l_reg, prod_l_next;
    logic signed [PW-1:0]  prod_r_reg, prod_r_next;
    logic                  bypass_reg, bypass_next;
    logic                  mark_reg, mark_next;
    dcr_pkg::pair_t        byp_pair_reg, byp_pair_next;
    logic                  m_valid_reg, m_valid_next;
    dcr_pkg::pair_t        m_data_reg, m_data_next;
    logic                  m_last_reg, m_last_next;
    logic                  m_user_reg, m_user_next;

    logic signed [CW-1:0]  cf_l;
    logic signed [CW-1:0]  cf_r;
    logic signed [VW-1:0]  v_l;
    logic signed [VW-1:0]  v_r;
    logic signed [PW-1:0]  mul_l;
    logic signed [PW-1:0]  mul_r;
    logic signed [VW-1:0]  rnd_l;
    logic signed [VW-1:0]  rnd_r;
    logic [AW-1:0]         acc_dec;
    logic signed [AW:0]    t_s;
    logic                  out_free;

    assign job_ready = (state_reg == ST_IDLE);
    assign out_free  = !m_valid_reg || m_tready;

    // Horner datapath: v = floor(prod / 2^12) + c * 2^12, prod' = v * tq
    always_comb begin
        cf_l  = $signed(hl_reg[hstep_reg]);
        cf_r  = $signed(hr_reg[hstep_reg]);
        v_l   = VW'(prod_l_reg >>> TQB) + (VW'(cf_l) <<< TQB);
        v_r   = VW'(prod_r_reg >>> TQB) + (VW'(cf_r) <<< TQB);
        mul_l = v_l * tq_reg;
        mul_r = v_r * tq_reg;
        rnd_l = (v_l + VW'(1 << TQB)) >>> (TQB + 1);
        rnd_r = (v_r + VW'(1 << TQB)) >>> (TQB + 1);
    end

    // next whole unit and its position t = 1 - acc
    always_comb begin
        acc_dec = acc_reg - AW'(UNITY);
        t_s     = $signed({1'b0, AW'(UNITY)}) - $signed({1'b0, acc_dec});
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        hstep_next    = hstep_reg;
        rem_next      = rem_reg;
        acc_next      = acc_reg;
        tq_next       = tq_reg;
        hl_next       = hl_reg;
        hr_next       = hr_reg;
        prod_l_next   = prod_l_reg;
        prod_r_next   = prod_r_reg;
        bypass_next   = bypass_reg;
        mark_next     = mark_reg;
        byp_pair_next = byp_pair_reg;
        m_valid_next  = m_valid_reg & ~m_tready;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        m_user_next   = m_user_reg;
        case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    hl_next = horner_coefs(job.hist[0].left, job.hist[1].left,
                                           job.hist[2].left, job.hist[3].left);
                    hr_next = horner_coefs(job.hist[0].right, job.hist[1].right,
                                           job.hist[2].right, job.hist[3].right);
                    acc_next      = job.acc;
                    rem_next      = job.count;
                    bypass_next   = job.bypass;
                    mark_next     = job.mark;
                    byp_pair_next = job.hist[3];
                    state_next    = job.bypass ? ST_FIN : ST_PHASE;
                end
            end
            ST_PHASE: begin
                acc_next    = acc_dec;
                tq_next     = TW'(t_s >>> (F - TQB));
                prod_l_next = '0;
                prod_r_next = '0;
                hstep_next  = 2'd0;
                state_next  = ST_MUL;
            end
            ST_MUL: begin
                prod_l_next = mul_l;
                prod_r_next = mul_r;
                hstep_next  = hstep_reg + 2'd1;
                if (hstep_reg == 2'd2) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (bypass_reg) begin
                        m_data_next = byp_pair_reg;
                    end else begin
                        m_data_next.left  = dcr_pkg::sat_sample(rnd_l);
                        m_data_next.right = dcr_pkg::sat_sample(rnd_r);
                    end
                    m_last_next = (rem_reg == NW'(1));
                    m_user_next = mark_reg;
                    mark_next   = 1'b0;
                    rem_next    = rem_reg - NW'(1);
                    state_next  = (rem_reg == NW'(1)) ? ST_IDLE : ST_PHASE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        hstep_reg    <= hstep_next;
        rem_reg      <= rem_next;
        acc_reg      <= acc_next;
        tq_reg       <= tq_next;
        hl_reg       <= hl_next;
        hr_reg       <= hr_next;
        prod_l_reg   <= prod_l_next;
        prod_r_reg   <= prod_r_next;
        bypass_reg   <= bypass_next;
        mark_reg     <= mark_next;
        byp_pair_reg <= byp_pair_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
        m_user_reg   <= m_user_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

>>> rtl/core/downmix_cubic_resampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// downmix_cubic_resampler: multichannel to stereo downmix with cubic resampling
// Front end mixes and tracks phase, a short job queue decouples it from the
// interpolation engine, which drives the result stream from a register.
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  s_       in         tdata: ch0..ch7 (16 b each), tlast: buffer end
//  m_       out        tdata: left, right (16 b each), tlast: last of frame,
//                      tuser: buffer mark
//  cfg_     in         addr 0: channel count, addr 1: phase step (Q4.16)
//
//  Front end takes a frame per cycle while the job queue has room.
//  Back end loads a job, then for each interpolated result steps through phase,
//  three Horner multiplies and round; a bypassed frame goes straight to output.
//  Result stalls hold the back end in its final step; the queue then fills.
//  Synchronous active-low reset; configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
module downmix_cubic_resampler #(
    parameter int QUEUE_DEPTH = dcr_pkg::QUEUE_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dcr_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [dcr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // source frames
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dcr_pkg::S_TDATA_W-1:0]   s_tdata,   // ch0 .. ch7
    input  logic                            s_tlast,
    // stereo results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dcr_pkg::M_TDATA_W-1:0]   m_tdata,   // out_left, out_right
    output logic                            m_tlast,
    output logic                            m_tuser    // buffer_mark
);

    logic          fq_valid;
    logic          fq_ready;
    dcr_pkg::job_t fq_job;
    logic          qb_valid;
    logic          qb_ready;
    dcr_pkg::job_t qb_job;

    dcr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    dcr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_job    (fq_job),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_job   (qb_job)
    );

    dcr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

>>> rtl/core/dcr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcr_checker: port-level checks for the downmix cubic resampler
// Watches the top-level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
`include "downmix_cubic_resampler_assert.svh"

module dcr_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           cfg_ready,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [dcr_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                           m_tlast,
    input logic                           m_tuser
);

    // a stalled result keeps its payload
    `DCR_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // a stalled result keeps its flags
    `DCR_ASSERT(a_out_flags, m_tvalid && !m_tready |=> $stable(m_tlast) && $stable(m_tuser))

    // reset empties the output register
    `DCR_ASSERT_ALWAYS(a_rst_out_empty, !aresetn |=> !m_tvalid)

    // reset empties the job queue, so frames are taken right away
    `DCR_ASSERT_ALWAYS(a_rst_in_open, !aresetn |=> s_tready)

    // configuration writes are never back-pressured
    `DCR_ASSERT(a_cfg_open, aresetn |-> cfg_ready)

endmodule

bind downmix_cubic_resampler dcr_checker u_dcr_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_ready (cfg_ready),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
);

>>> verif/downmix_resampler_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// downmix_resampler_checker: result predictor and comparator
// Watches the configuration, source and result channels of the downmix cubic
// resampler, predicts every stereo pair from each accepted source frame and
// compares the pairs leaving the block against them in order.
// ----------------------------------------------------------------------------
module downmix_resampler_checker
    import dcr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,    // ch0 .. ch7
    input  logic                   s_tlast,    // buffer end
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,    // out_left, out_right
    input  logic                   m_tlast,    // last pair of the frame
    input  logic                   m_tuser,    // buffer mark
    output int                     mismatch_count,
    output int                     pairs_pending,
    output int                     pairs_checked
);

    typedef struct {
        sample_t left;
        sample_t right;
        logic    last;
        logic    mark;
    } stereo_pair_t;

    // expected pairs in arrival order, read at exp_head, written at exp_tail
    stereo_pair_t expected_pairs [int];
    int           exp_head;
    int           exp_tail;

    // predictor state, kept at the block's widths
    sample_t             hist_left  [4];   // index 0 oldest
    sample_t             hist_right [4];
    logic [ACC_W-1:0]    phase_acc;
    logic                held_mark;
    logic [CHAN_W-1:0]   chan_count;
    logic [STEP_W-1:0]   phase_step;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("[%0t] mismatch on %s at pair %0d: got %0d, expected %0d",
                 $realtime, what, pairs_checked, got, want);
    endtask

    function automatic sample_t clamp_sample(input longint v);
        if (v > MAX_SAMPLE) begin
            return sample_t'(MAX_SAMPLE);
        end else if (v < MIN_SAMPLE) begin
            return sample_t'(MIN_SAMPLE);
        end
        return sample_t'(v);
    endfunction

    // Catmull-Rom through b..c, Horner form, products floored to TQ_BITS
    function automatic sample_t catmull_point(input longint a, input longint b,
                                              input longint c, input longint d,
                                              input longint tq);
        longint unit_q;
        longint k0;
        longint k1;
        longint k2;
        longint k3;
        longint v;
        unit_q = longint'(1) << TQ_BITS;
        k0 = 2 * b;
        k1 = c - a;
        k2 = 2 * a - 5 * b + 4 * c - d;
        k3 = -a + 3 * b - 3 * c + d;
        v = k3 * unit_q;
        v = ((v * tq) >>> TQ_BITS) + k2 * unit_q;
        v = ((v * tq) >>> TQ_BITS) + k1 * unit_q;
        v = ((v * tq) >>> TQ_BITS) + k0 * unit_q;
        return clamp_sample((v + unit_q) >>> (TQ_BITS + 1));
    endfunction

    // queue one pair; a held buffer mark rides on it and is consumed
    task automatic post_pair(input sample_t l, input sample_t r, input logic last);
        stereo_pair_t p;
        p.left  = l;
        p.right = r;
        p.last  = last;
        p.mark  = held_mark;
        held_mark = 1'b0;
        expected_pairs[exp_tail] = p;
        exp_tail++;
    endtask

    // downmix one frame into the history, then emit its pairs
    task automatic mix_and_resample(input logic [S_TDATA_W-1:0] frame, input logic buf_end);
        int      n;
        int      k;
        sample_t ch;
        sample_t l;
        sample_t r;
        longint  lsum;
        longint  rsum;
        longint  unity;
        longint  step;
        longint  diff;
        longint  acc;
        longint  limit;
        longint  tq;
        n = chan_count;
        if (n == 0) begin
            n = 1;
        end
        if (n > MAX_CHANNELS) begin
            n = MAX_CHANNELS;
        end
        held_mark = held_mark | buf_end;

        // sums in half-LSB units: twice the main channel plus each extra
        ch   = frame[0 +: SAMPLE_BITS];
        lsum = 2 * longint'(ch);
        rsum = lsum;
        if (n > 1) begin
            ch   = frame[SAMPLE_BITS +: SAMPLE_BITS];
            rsum = 2 * longint'(ch);
        end
        for (k = 2; k < n; k++) begin
            ch   = frame[k*SAMPLE_BITS +: SAMPLE_BITS];
            lsum += longint'(ch);
            rsum += longint'(ch);
        end
        l = clamp_sample(lsum >>> 1);
        r = clamp_sample(rsum >>> 1);

        for (k = 0; k < 3; k++) begin
            hist_left[k]  = hist_left[k+1];
            hist_right[k] = hist_right[k+1];
        end
        hist_left[3]  = l;
        hist_right[3] = r;

        // near-unity step passes the newest pair straight through
        unity = longint'(1) << PHASE_FRAC_BITS;
        step  = longint'(phase_step);
        diff  = (step > unity) ? step - unity : unity - step;
        if (diff <= unity / 10000) begin
            post_pair(l, r, 1'b1);
            return;
        end

        acc   = longint'(phase_acc) + step;
        limit = (longint'(MAX_OUTPUTS) << PHASE_FRAC_BITS) | (unity - 1);
        if (acc > limit) begin
            acc = limit;
        end
        k = 0;
        while (acc >= unity && k < MAX_OUTPUTS) begin
            acc -= unity;
            // several units due: t goes to zero or below and extrapolates
            tq = (unity - acc) >>> (PHASE_FRAC_BITS - TQ_BITS);
            post_pair(catmull_point(hist_left[0], hist_left[1], hist_left[2],
                                    hist_left[3], tq),
                      catmull_point(hist_right[0], hist_right[1], hist_right[2],
                                    hist_right[3], tq),
                      acc < unity);
            k++;
        end
        phase_acc = ACC_W'(acc);
    endtask

    // channel monitor
    always @(posedge aclk) begin
        stereo_pair_t want;
        sample_t      got_left;
        sample_t      got_right;
        if (!aresetn) begin
            for (int k = 0; k < 4; k++) begin
                hist_left[k]  = '0;
                hist_right[k] = '0;
            end
            phase_acc      = '0;
            held_mark      = 1'b0;
            chan_count     = CHAN_W'(2);
            phase_step     = STEP_W'(65536);
            mismatch_count = 0;
            pairs_checked  = 0;
            expected_pairs.delete();
            exp_head       = 0;
            exp_tail       = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_addr == REG_CHANNEL_COUNT) begin
                    chan_count = cfg_wdata[CHAN_W-1:0];
                end else begin
                    phase_step = cfg_wdata[STEP_W-1:0];
                end
            end

            if (m_tvalid && m_tready) begin
                got_left  = m_tdata[0 +: SAMPLE_BITS];
                got_right = m_tdata[SAMPLE_BITS +: SAMPLE_BITS];
                if (exp_tail == exp_head) begin
                    report_mismatch("unexpected pair (left)", got_left, 0);
                end else begin
                    want = expected_pairs[exp_head];
                    expected_pairs.delete(exp_head);
                    exp_head++;
                    if (got_left !== want.left) begin
                        report_mismatch("out_left", got_left, want.left);
                    end
                    if (got_right !== want.right) begin
                        report_mismatch("out_right", got_right, want.right);
                    end
                    if (m_tlast !== want.last) begin
                        report_mismatch("run_last", m_tlast, want.last);
                    end
                    if (m_tuser !== want.mark) begin
                        report_mismatch("buffer_mark", m_tuser, want.mark);
                    end
                end
                pairs_checked++;
            end

            if (s_tvalid && s_tready) begin
                mix_and_resample(s_tdata, s_tlast);
            end
        end
        pairs_pending = exp_tail - exp_head;
    end

endmodule

>>> verif/tb_downmix_cubic_resampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_downmix_cubic_resampler: stimulus and verdict for the resampler
// Drives directed frames over the edge settings, then random register
// settings with random or smooth frames, random stalls on both channels and
// one long output hold-off. A checker beside the block compares every pair.
// ----------------------------------------------------------------------------
module tb_downmix_cubic_resampler;

    import dcr_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 100;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_FRAMES   = 39;
    localparam int PRESSURE_PHASE = 3;
    localparam int LIMIT_NS       = 20_000_000;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    cfg_reg_t               cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;    // ch0 .. ch7
    logic                   s_tlast;    // buffer end
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;    // out_left, out_right
    logic                   m_tlast;    // last pair of the frame
    logic                   m_tuser;    // buffer mark

    int mismatch_count;
    int pairs_pending;
    int pairs_checked;

    int frames_sent;
    int settings_used;
    bit hold_request;
    bit hold_done;
    int walk [MAX_CHANNELS];

    downmix_cubic_resampler dut (.*);

    downmix_resampler_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #HALF_PERIOD aclk = ~aclk;
    end

    initial begin
        #(LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

    // mostly back to back, sometimes a short gap, rarely a long gap
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) begin
            return 0;
        end else if (r < 18) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic sample_t random_sample();
        case ($urandom_range(0, 9))
            0: return sample_t'(MAX_SAMPLE);
            1: return sample_t'(MIN_SAMPLE);
            2: return sample_t'(int'($urandom_range(0, 127)) - 64);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // a on even channels, b on odd channels
    function automatic logic [S_TDATA_W-1:0] fill_frame(input sample_t a, input sample_t b);
        logic [S_TDATA_W-1:0] f;
        for (int k = 0; k < MAX_CHANNELS; k++) begin
            f[k*SAMPLE_BITS +: SAMPLE_BITS] = (k % 2 == 0) ? a : b;
        end
        return f;
    endfunction

    // result receiver: short stalls, ready bursts, and one long hold-off
    initial begin
        logic sink_level;
        int   sink_len;
        m_tready   = 1'b0;
        sink_level = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_request && !hold_done) begin
                sink_level = 1'b0;
                sink_len   = HOLD_CYCLES;
                hold_done  = 1'b1;
            end else if (sink_level == 1'b0) begin
                sink_level = 1'b1;
                sink_len   = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80)
                                                         : $urandom_range(1, 6);
            end else begin
                sink_level = 1'b0;
                sink_len   = pick_gap();
            end
            if (sink_len > 0) begin
                @(negedge aclk);
                m_tready <= sink_level;
                repeat (sink_len - 1) @(negedge aclk);
            end
        end
    end

    // one source transfer, after an optional idle gap
    task automatic send_frame(input logic [S_TDATA_W-1:0] frame, input logic buf_end);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tdata  <= frame;
        s_tlast  <= buf_end;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        frames_sent++;
    endtask

    // drop valid, wait for every pair, then let frames without pairs drain
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pairs_pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_addr  <= idx;
        cfg_wdata <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_registers(input int chans, input int step);
        wait_idle();
        write_register(REG_CHANNEL_COUNT, CFG_DATA_W'(chans));
        write_register(REG_PHASE_STEP, CFG_DATA_W'(step));
        settings_used++;
    endtask

    function automatic int pick_channels();
        if ($urandom_range(0, 2) == 0) begin
            return $urandom_range(0, 15);
        end
        return $urandom_range(1, MAX_CHANNELS);
    endfunction

    function automatic int pick_step();
        case ($urandom_range(0, 9))
            0: return $urandom_range(65530, 65542);     // bypass window
            1: begin
                case ($urandom_range(0, 5))
                    0: return 0;
                    1: return 20'hFFFFF;
                    2: return 16384;
                    3: return 524288;
                    4: return 65529;
                    default: return 65543;
                endcase
            end
            2, 3: return $urandom_range(16384, 65529);
            4, 5: return $urandom_range(65543, 140000);
            6: return $urandom_range(140000, 524288);
            7: return $urandom_range(0, 20'hFFFFF);
            default: return $urandom_range(16384, 524288);
        endcase
    endfunction

    // stimulus
    initial begin
        logic [S_TDATA_W-1:0] frame;
        bit                   smooth;
        int                   step;
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_addr      = REG_CHANNEL_COUNT;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        frames_sent   = 0;
        settings_used = 1;
        hold_request  = 1'b0;
        hold_done     = 1'b0;
        for (int k = 0; k < MAX_CHANNELS; k++) begin
            walk[k] = 0;
        end
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings, plain stereo passthrough
        send_frame(fill_frame(sample_t'(MAX_SAMPLE), sample_t'(MIN_SAMPLE)), 1'b0);
        send_frame(fill_frame(sample_t'(MIN_SAMPLE), sample_t'(MAX_SAMPLE)), 1'b1);
        send_frame(fill_frame(sample_t'(0), sample_t'(-1)), 1'b0);
        // all eight channels, top edge of the bypass window, sums clamp
        set_registers(8, 65542);
        send_frame(fill_frame(sample_t'(MAX_SAMPLE), sample_t'(MAX_SAMPLE)), 1'b0);
        send_frame(fill_frame(sample_t'(MIN_SAMPLE), sample_t'(MIN_SAMPLE)), 1'b1);
        send_frame(fill_frame(sample_t'(MAX_SAMPLE), sample_t'(MIN_SAMPLE)), 1'b0);
        // zero channel count acts as mono, just below the bypass window
        set_registers(0, 65529);
        send_frame(fill_frame(sample_t'(16'h1234), sample_t'(MIN_SAMPLE)), 1'b0);
        send_frame(fill_frame(sample_t'(MIN_SAMPLE), sample_t'(MAX_SAMPLE)), 1'b0);
        send_frame(fill_frame(sample_t'(-1), sample_t'(1)), 1'b1);
        // count above the maximum, largest step: saturated accumulator,
        // extrapolated points
        set_registers(15, 20'hFFFFF);
        send_frame(fill_frame(sample_t'(MAX_SAMPLE), sample_t'(MIN_SAMPLE)), 1'b0);
        send_frame(fill_frame(sample_t'(MIN_SAMPLE), sample_t'(MAX_SAMPLE)), 1'b0);
        send_frame(fill_frame(sample_t'(0), sample_t'(0)), 1'b1);
        // zero step: no pairs, buffer mark held over
        set_registers(1, 0);
        send_frame(fill_frame(sample_t'(16'h5555), sample_t'(16'hAAAA)), 1'b1);
        send_frame(fill_frame(sample_t'(16'h0123), sample_t'(16'h7654)), 1'b0);
        // quarter step with three channels: pairs on every fourth frame
        set_registers(3, 16384);
        send_frame(fill_frame(sample_t'(MAX_SAMPLE), sample_t'(0)), 1'b0);
        send_frame(fill_frame(sample_t'(0), sample_t'(MIN_SAMPLE)), 1'b1);
        send_frame(fill_frame(sample_t'(MIN_SAMPLE), sample_t'(MAX_SAMPLE)), 1'b0);
        send_frame(fill_frame(sample_t'(100), sample_t'(-100)), 1'b0);
        // bottom edge of the bypass window
        set_registers(2, 65530);
        send_frame(fill_frame(sample_t'(-2), sample_t'(3)), 1'b0);
        send_frame(fill_frame(sample_t'(MAX_SAMPLE), sample_t'(MIN_SAMPLE)), 1'b1);

        // random settings, each with a run of random or smooth frames
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            step = (p == PRESSURE_PHASE) ? 3 * 65536 + $urandom_range(0, 65535)
                                         : pick_step();
            set_registers(pick_channels(), step);
            smooth = $urandom_range(0, 1);
            if (p == PRESSURE_PHASE) begin
                hold_request = 1'b1;
            end
            for (int i = 0; i < PHASE_FRAMES; i++) begin
                for (int k = 0; k < MAX_CHANNELS; k++) begin
                    if (smooth) begin
                        walk[k] = walk[k] + int'($urandom_range(0, 3000)) - 1500;
                        frame[k*SAMPLE_BITS +: SAMPLE_BITS] = walk[k][SAMPLE_BITS-1:0];
                    end else begin
                        frame[k*SAMPLE_BITS +: SAMPLE_BITS] = random_sample();
                    end
                end
                send_frame(frame, $urandom_range(0, 7) == 0);
            end
        end

        wait_idle();
        $display("covered %0d frames over %0d register settings, %0d stereo pairs checked",
                 frames_sent, settings_used, pairs_checked);
        $display("including a %0d-cycle output hold-off under input back-pressure",
                 HOLD_CYCLES);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/dcr_pkg.sv
rtl/core/dcr_front.sv
rtl/core/dcr_queue.sv
rtl/core/dcr_back.sv
rtl/core/downmix_cubic_resampler.sv
rtl/core/dcr_checker.sv
verif/downmix_resampler_checker.sv
verif/tb_downmix_cubic_resampler.sv
